// File: hw/rtl/mxn_pkg.sv
// Shared types and constants for the mutual exclusion node.
// No dependencies; used by mxn_front, mxn_back and mutual_exclusion_node_top.
package mxn_pkg;

  localparam int MAX_NODES = 16;
  localparam int ID_W      = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int CLK_W     = 32;

  // configuration register indexes
  localparam logic CFG_OWN_ID     = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  typedef enum logic [1:0] {
    KIND_LOCAL_REQ  = 2'd0,
    KIND_LOCAL_EXIT = 2'd1,
    KIND_RECV_REQ   = 2'd2,
    KIND_RECV_REPLY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ACT_REQUEST = 2'd0,
    ACT_REPLY   = 2'd1,
    ACT_GRANT   = 2'd2
  } action_t;

  // classified request handed from front to back
  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   sender;
    logic [CLK_W-1:0]  mclk;
    logic              deferable;
  } cmd_t;

endpackage

// File: hw/rtl/mxn_front.sv
// Front end: accepts input requests, classifies them and holds them in a
// two-entry queue for the back end. Depends on mxn_pkg.
module mxn_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_kind,
  input  logic [mxn_pkg::ID_W-1:0]  in_sender_id,
  input  logic [mxn_pkg::CLK_W-1:0] in_msg_clock,
  input  logic [mxn_pkg::ID_W-1:0]  own_id,
  input  logic [mxn_pkg::CNT_W-1:0] n_used,
  output logic                      cmd_valid,
  output mxn_pkg::cmd_t             cmd,
  input  logic                      cmd_take
);

  mxn_pkg::cmd_t fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  mxn_pkg::cmd_t in_cmd;

  always_comb begin
    in_cmd.kind      = mxn_pkg::kind_t'(in_kind);
    in_cmd.sender    = in_sender_id;
    in_cmd.mclk      = in_msg_clock;
    in_cmd.deferable = ({1'b0, in_sender_id} < n_used) && (in_sender_id != own_id);
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = fifo_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_take;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// File: hw/rtl/mxn_back.sv
// Back end: holds the protocol state and carries out queued requests, at most one
// result per cycle into an output register when not stalled. Depends on mxn_pkg.
module mxn_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_valid,
  input  mxn_pkg::cmd_t             cmd,
  output logic                      cmd_take,
  input  logic [mxn_pkg::ID_W-1:0]  own_id,
  input  logic [mxn_pkg::CNT_W-1:0] n_used,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_action,
  output logic [mxn_pkg::ID_W-1:0]  out_dest_id,
  output logic [mxn_pkg::CLK_W-1:0] out_clock,
  output logic                      out_last
);

  localparam int ID_W  = mxn_pkg::ID_W;
  localparam int CNT_W = mxn_pkg::CNT_W;
  localparam int CLK_W = mxn_pkg::CLK_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MOD   = 4'b0010,
    S_BCAST = 4'b0100,
    S_EXIT  = 4'b1000
  } state_t;

  function automatic logic [CLK_W-1:0] sat_inc(input logic [CLK_W-1:0] v);
    sat_inc = (v == {CLK_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  state_t                 state_r, state_nxt;
  logic [CLK_W-1:0]       clock_r, clock_nxt;
  logic                   requesting_r, requesting_nxt;
  logic [CLK_W-1:0]       stamp_r, stamp_nxt;
  logic [ID_W-1:0]        reply_cnt_r, reply_cnt_nxt;
  logic [mxn_pkg::MAX_NODES-1:0] defer_r, defer_nxt;
  logic [CNT_W-1:0]       dest_r, dest_nxt;
  logic [ID_W-1:0]        left_r, left_nxt;

  logic                   out_valid_r;
  logic [1:0]             out_action_r;
  logic [ID_W-1:0]        out_dest_r;
  logic [CLK_W-1:0]       out_clock_r;
  logic                   out_last_r;

  logic                   can_emit, emit;
  mxn_pkg::action_t       e_action;
  logic [ID_W-1:0]        e_dest;
  logic [CLK_W-1:0]       e_clock;
  logic                   e_last;

  logic [CLK_W-1:0]       hi, c1, c2;
  logic [ID_W-1:0]        n_m1;
  logic                   prio;
  logic [ID_W-1:0]        low_idx;
  logic [mxn_pkg::MAX_NODES-1:0] low_bit;
  logic [CNT_W-1:0]       d_inc, d1;

  assign can_emit = !out_valid_r || out_ready;
  assign n_m1     = ID_W'(n_used - 1'b1);
  assign hi       = (clock_r > cmd.mclk) ? clock_r : cmd.mclk;
  assign c1       = sat_inc(hi);
  assign c2       = sat_inc(c1);
  assign prio     = requesting_r && ((stamp_r < cmd.mclk) ||
                    ((stamp_r == cmd.mclk) && (own_id < cmd.sender)));
  assign d_inc    = dest_r + 1'b1;
  assign d1       = (d_inc == n_used) ? '0 : d_inc;

  always_comb begin
    low_idx = '0;
    for (int i = mxn_pkg::MAX_NODES - 1; i >= 0; i--) begin
      if (defer_r[i]) begin
        low_idx = ID_W'(i);
      end
    end
    low_bit = '0;
    low_bit[low_idx] = 1'b1;
  end

  always_comb begin
    state_nxt      = state_r;
    clock_nxt      = clock_r;
    requesting_nxt = requesting_r;
    stamp_nxt      = stamp_r;
    reply_cnt_nxt  = reply_cnt_r;
    defer_nxt      = defer_r;
    dest_nxt       = dest_r;
    left_nxt       = left_r;
    cmd_take       = 1'b0;
    emit           = 1'b0;
    e_action       = mxn_pkg::ACT_REPLY;
    e_dest         = '0;
    e_clock        = '0;
    e_last         = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && can_emit) begin
          cmd_take = 1'b1;
          case (cmd.kind)
            mxn_pkg::KIND_LOCAL_REQ: begin
              if (!requesting_r) begin
                requesting_nxt = 1'b1;
                reply_cnt_nxt  = '0;
                clock_nxt      = sat_inc(clock_r);
                stamp_nxt      = sat_inc(clock_r);
                dest_nxt       = {1'b0, own_id};
                left_nxt       = n_m1;
                state_nxt      = S_MOD;
              end
            end
            mxn_pkg::KIND_LOCAL_EXIT: begin
              requesting_nxt = 1'b0;
              reply_cnt_nxt  = '0;
              if (defer_r != '0) begin
                state_nxt = S_EXIT;
              end
            end
            mxn_pkg::KIND_RECV_REQ: begin
              if (prio && cmd.deferable) begin
                clock_nxt = c1;
                defer_nxt = defer_r | (mxn_pkg::MAX_NODES'(1) << cmd.sender);
              end else begin
                clock_nxt = c2;
                defer_nxt = defer_r & ~(mxn_pkg::MAX_NODES'(1) << cmd.sender);
                emit      = 1'b1;
                e_action  = mxn_pkg::ACT_REPLY;
                e_dest    = cmd.sender;
                e_clock   = c2;
              end
            end
            mxn_pkg::KIND_RECV_REPLY: begin
              clock_nxt = c1;
              if (requesting_r && (reply_cnt_r < n_m1)) begin
                reply_cnt_nxt = reply_cnt_r + 1'b1;
                if (reply_cnt_r + 1'b1 == n_m1) begin
                  emit     = 1'b1;
                  e_action = mxn_pkg::ACT_GRANT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_MOD: begin
        // reduce own id modulo the node count
        if (dest_r >= n_used) begin
          dest_nxt = dest_r - n_used;
        end else begin
          state_nxt = S_BCAST;
        end
      end
      S_BCAST: begin
        if (can_emit) begin
          emit     = 1'b1;
          e_action = mxn_pkg::ACT_REQUEST;
          e_dest   = ID_W'(d1);
          e_clock  = clock_r;
          e_last   = (left_r == ID_W'(1));
          dest_nxt = d1;
          left_nxt = left_r - 1'b1;
          if (left_r == ID_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EXIT: begin
        if (can_emit) begin
          emit      = 1'b1;
          clock_nxt = sat_inc(clock_r);
          e_action  = mxn_pkg::ACT_REPLY;
          e_dest    = low_idx;
          e_clock   = sat_inc(clock_r);
          defer_nxt = defer_r & ~low_bit;
          e_last    = ((defer_r & ~low_bit) == '0);
          if (e_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      clock_r      <= '0;
      requesting_r <= 1'b0;
      stamp_r      <= CLK_W'(10);
      reply_cnt_r  <= '0;
      defer_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clock_r      <= clock_nxt;
      requesting_r <= requesting_nxt;
      stamp_r      <= stamp_nxt;
      reply_cnt_r  <= reply_cnt_nxt;
      defer_r      <= defer_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dest_r <= dest_nxt;
    left_r <= left_nxt;
    if (emit) begin
      out_action_r <= e_action;
      out_dest_r   <= e_dest;
      out_clock_r  <= e_clock;
      out_last_r   <= e_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_action  = out_action_r;
  assign out_dest_id = out_dest_r;
  assign out_clock   = out_clock_r;
  assign out_last    = out_last_r;

  a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    clock_r >= $past(clock_r))
    else $error("lamport clock went backwards");

  a_idle_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    !requesting_r |-> (reply_cnt_r == '0))
    else $error("reply count nonzero while not requesting");

  a_exit_drains_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXIT) && can_emit |=>
      ($countones(defer_r) + 1 == $countones($past(defer_r))))
    else $error("exit sweep did not clear exactly one deferred entry");

  a_grant_requesting: assert property (@(posedge clk) disable iff (!rst_n)
    emit && (e_action == mxn_pkg::ACT_GRANT) |-> requesting_r)
    else $error("grant issued while not requesting");

endmodule

// File: hw/rtl/mutual_exclusion_node_top.sv
// One node of a Ricart-Agrawala mutual exclusion protocol: a two-entry request
// queue ahead of a sequencer emitting at most one result per cycle unless stalled.
// A received request, a received reply or a local exit with nothing deferred
// is handled in the idle state. A local request first reduces own_id modulo
// the node count, then sends one request per peer (node count minus one). A
// local exit sends one reply per deferred requester, lowest id first. All
// results pass through one output register, so a stall on the result side
// holds the sequencer while the queue still takes up to two further requests.
// Depends on mxn_pkg, mxn_front, mxn_back.
module mutual_exclusion_node_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_kind,
  input  logic [mxn_pkg::ID_W-1:0]  in_sender_id,
  input  logic [mxn_pkg::CLK_W-1:0] in_msg_clock,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_action,
  output logic [mxn_pkg::ID_W-1:0]  out_dest_id,
  output logic [mxn_pkg::CLK_W-1:0] out_clock,
  output logic                      out_last,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [4:0]                cfg_wdata
);

  logic [mxn_pkg::ID_W-1:0]  own_id_r;
  logic [4:0]                node_count_r;
  logic [mxn_pkg::CNT_W-1:0] n_used;
  logic                      cmd_valid;
  logic                      cmd_take;
  mxn_pkg::cmd_t             cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r     <= '0;
      node_count_r <= 5'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        mxn_pkg::CFG_OWN_ID:     own_id_r     <= cfg_wdata[mxn_pkg::ID_W-1:0];
        mxn_pkg::CFG_NODE_COUNT: node_count_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // node count clamped to 2..MAX_NODES
  always_comb begin
    if (node_count_r < 5'd2) begin
      n_used = mxn_pkg::CNT_W'(2);
    end else if ({{(32-5){1'b0}}, node_count_r} > mxn_pkg::MAX_NODES) begin
      n_used = mxn_pkg::CNT_W'(mxn_pkg::MAX_NODES);
    end else begin
      n_used = mxn_pkg::CNT_W'(node_count_r);
    end
  end

  mxn_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_sender_id (in_sender_id),
    .in_msg_clock (in_msg_clock),
    .own_id       (own_id_r),
    .n_used       (n_used),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  mxn_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take),
    .own_id      (own_id_r),
    .n_used      (n_used),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_action  (out_action),
    .out_dest_id (out_dest_id),
    .out_clock   (out_clock),
    .out_last    (out_last)
  );

endmodule
